// ----- rtl/buv_pkg.sv -----
// Shared types and constants for the bond unit vector block.
// No dependencies; every other file imports this package.
`default_nettype none
package buv_pkg;
   localparam int IDX_W       = 11;
   localparam int COORD_W     = 24;
   localparam int DIFF_W      = 25;
   localparam int UNIT_W      = 18;
   localparam int SUMSQ_W     = 50;
   localparam int NORM_W      = 62;
   localparam int ROOT_W      = 31;
   localparam int QUO_W       = 17;
   localparam int SHIFT_W     = 5;
   localparam int NUMER_W     = DIFF_W + 16 + 30;
   localparam int QUEUE_DEPTH = 2;

   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
      logic                     last;
   } bond_type;

   typedef enum logic [1:0] {FE_IDLE, FE_FETCH, FE_PUSH} front_state_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_SQUARE, BE_SUM, BE_NORM, BE_ROOT, BE_DIVIDE, BE_DONE
   } back_state_type;
endpackage
`default_nettype wire

// ----- rtl/buv_front.sv -----
// Front end: takes command beats, owns the atom coordinate table and forms
// the bond difference vector for the queue. Depends on buv_pkg.
`default_nettype none
module buv_front #(
   parameter int ATOM_COUNT = 2048
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic                                  req_func,
   input  wire logic [buv_pkg::IDX_W-1:0]             req_atom_first,
   input  wire logic [buv_pkg::IDX_W-1:0]             req_atom_second,
   input  wire logic signed [buv_pkg::COORD_W-1:0]    req_coord_x,
   input  wire logic signed [buv_pkg::COORD_W-1:0]    req_coord_y,
   input  wire logic signed [buv_pkg::COORD_W-1:0]    req_coord_z,
   input  wire logic                                  req_last_in,
   output logic                                       push_valid,
   output buv_pkg::bond_type                          push_data,
   input  wire logic                                  push_ready
);
   import buv_pkg::*;

   localparam int AW = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;

   logic signed [COORD_W-1:0] mem_x [ATOM_COUNT];
   logic signed [COORD_W-1:0] mem_y [ATOM_COUNT];
   logic signed [COORD_W-1:0] mem_z [ATOM_COUNT];

   front_state_type state_ff, state_in;
   logic [AW-1:0] addr1_ff, addr2_ff;
   logic ok1_ff, ok2_ff, last_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff;
   logic accept, first_ok, second_ok;
   logic signed [DIFF_W-1:0] ax1, ay1, az1, ax2, ay2, az2;

   assign accept    = start && !busy;
   assign first_ok  = 32'(req_atom_first) < ATOM_COUNT;
   assign second_ok = 32'(req_atom_second) < ATOM_COUNT;

   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_WRITE && first_ok) begin
         mem_x[AW'(req_atom_first)] <= req_coord_x;
         mem_y[AW'(req_atom_first)] <= req_coord_y;
         mem_z[AW'(req_atom_first)] <= req_coord_z;
      end
      x1_ff <= mem_x[addr1_ff];
      y1_ff <= mem_y[addr1_ff];
      z1_ff <= mem_z[addr1_ff];
      x2_ff <= mem_x[addr2_ff];
      y2_ff <= mem_y[addr2_ff];
      z2_ff <= mem_z[addr2_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         addr1_ff <= AW'(req_atom_first);
         addr2_ff <= AW'(req_atom_second);
         ok1_ff   <= first_ok;
         ok2_ff   <= second_ok;
         last_ff  <= req_last_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      push_valid = 1'b0;
      case (state_ff)
         FE_IDLE: begin
            busy = 1'b0;
            if (start && req_func == FUNC_COMPUTE) state_in = FE_FETCH;
         end
         FE_FETCH: state_in = FE_PUSH;
         FE_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) state_in = FE_IDLE;
         end
         default: state_in = FE_IDLE;
      endcase
   end

   // out-of-range atoms read as the origin
   assign ax1 = ok1_ff ? DIFF_W'(x1_ff) : '0;
   assign ay1 = ok1_ff ? DIFF_W'(y1_ff) : '0;
   assign az1 = ok1_ff ? DIFF_W'(z1_ff) : '0;
   assign ax2 = ok2_ff ? DIFF_W'(x2_ff) : '0;
   assign ay2 = ok2_ff ? DIFF_W'(y2_ff) : '0;
   assign az2 = ok2_ff ? DIFF_W'(z2_ff) : '0;

   assign push_data.dx   = ax2 - ax1;
   assign push_data.dy   = ay2 - ay1;
   assign push_data.dz   = az2 - az1;
   assign push_data.last = last_ff;
endmodule
`default_nettype wire

// ----- rtl/buv_queue.sv -----
// Two-entry queue of bond difference vectors between front and back end.
// Depends on buv_pkg.
`default_nettype none
module buv_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  buv_pkg::bond_type      push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output buv_pkg::bond_type      pop_data,
   input  wire logic              pop_ready
);
   import buv_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   bond_type entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   count_ff;
   logic do_push, do_pop;

   assign push_ready = count_ff != (PW+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
      if (do_push) entry_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- rtl/buv_back.sv -----
// Back end: squares, normalizes, takes a bit-serial square root and runs
// three bit-serial dividers to produce the unit vector. Depends on buv_pkg.
`default_nettype none
module buv_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pop_valid,
   input  buv_pkg::bond_type                        pop_data,
   output logic                                     pop_ready,
   output logic                                     rsp_valid,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_x,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_y,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_z,
   output logic                                     rsp_zero_length,
   output logic                                     rsp_last_out
);
   import buv_pkg::*;

   back_state_type state_ff, state_in;
   logic [4:0] step_ff;
   logic [DIFF_W-1:0]  mag_ff [3];
   logic               neg_ff [3];
   logic [SUMSQ_W-1:0] sq_ff  [3];
   logic [NORM_W-1:0]  t_ff;
   logic [SHIFT_W-1:0] k_ff;
   logic [ROOT_W+1:0]  rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [31:0]        drem_ff [3];
   logic [QUO_W-1:0]   nlow_ff [3];
   logic [QUO_W-1:0]   quo_ff  [3];
   logic last_ff, zero_ff;
   logic [UNIT_W-1:0]  unit_ff [3];
   logic valid_ff;

   logic [ROOT_W+3:0] cur, trial;
   logic [NUMER_W-1:0] numer [3];
   logic [32:0] dtrial [3];
   logic [SUMSQ_W:0] sum;

   assign sum   = (SUMSQ_W+1)'(sq_ff[0]) + (SUMSQ_W+1)'(sq_ff[1])
                + (SUMSQ_W+1)'(sq_ff[2]);
   assign cur   = {rem_ff, t_ff[NORM_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         numer[i]  = NUMER_W'(mag_ff[i]) << (16 + int'(k_ff));
         dtrial[i] = {drem_ff[i], nlow_ff[i][QUO_W-1]};
      end
   end

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      case (state_ff)
         BE_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) state_in = BE_SQUARE;
         end
         BE_SQUARE: state_in = BE_SUM;
         BE_SUM:    state_in = (sum == '0) ? BE_DONE : BE_NORM;
         BE_NORM:   if (t_ff[NORM_W-1 -: 2] != 2'b00) state_in = BE_ROOT;
         BE_ROOT:   if (step_ff == 5'd0) state_in = BE_DIVIDE;
         BE_DIVIDE: if (step_ff == 5'd0) state_in = BE_DONE;
         BE_DONE:   state_in = BE_IDLE;
         default:   state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= state_ff == BE_DONE;
      end

      case (state_ff)
         BE_IDLE: begin
            mag_ff[0] <= pop_data.dx[DIFF_W-1] ? DIFF_W'(-pop_data.dx) : pop_data.dx;
            mag_ff[1] <= pop_data.dy[DIFF_W-1] ? DIFF_W'(-pop_data.dy) : pop_data.dy;
            mag_ff[2] <= pop_data.dz[DIFF_W-1] ? DIFF_W'(-pop_data.dz) : pop_data.dz;
            neg_ff[0] <= pop_data.dx[DIFF_W-1];
            neg_ff[1] <= pop_data.dy[DIFF_W-1];
            neg_ff[2] <= pop_data.dz[DIFF_W-1];
            last_ff   <= pop_data.last;
         end
         BE_SQUARE: begin
            for (int i = 0; i < 3; i++) begin
               sq_ff[i] <= SUMSQ_W'(mag_ff[i] * mag_ff[i]);
            end
         end
         BE_SUM: begin
            t_ff    <= NORM_W'(sum);
            k_ff    <= '0;
            zero_ff <= sum == '0;
         end
         BE_NORM: begin
            // jump four places at once while far below the target window
            if (t_ff[NORM_W-1 -: 8] == 8'd0) begin
               t_ff <= t_ff << 8;
               k_ff <= k_ff + SHIFT_W'(4);
            end else if (t_ff[NORM_W-1 -: 2] == 2'b00) begin
               t_ff <= t_ff << 2;
               k_ff <= k_ff + SHIFT_W'(1);
            end
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= 5'(ROOT_W - 1);
         end
         BE_ROOT: begin
            if (cur >= trial) begin
               rem_ff  <= (ROOT_W+2)'(cur - trial);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= (ROOT_W+2)'(cur);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            t_ff    <= t_ff << 2;
            if (step_ff == 5'd0) begin
               for (int i = 0; i < 3; i++) begin
                  drem_ff[i] <= 32'(numer[i][NUMER_W-1:QUO_W]);
                  nlow_ff[i] <= numer[i][QUO_W-1:0];
                  quo_ff[i]  <= '0;
               end
               step_ff <= 5'(QUO_W - 1);
            end else begin
               step_ff <= step_ff - 5'd1;
            end
         end
         BE_DIVIDE: begin
            for (int i = 0; i < 3; i++) begin
               if (dtrial[i] >= 33'(root_ff)) begin
                  drem_ff[i] <= 32'(dtrial[i] - 33'(root_ff));
                  quo_ff[i]  <= {quo_ff[i][QUO_W-2:0], 1'b1};
               end else begin
                  drem_ff[i] <= 32'(dtrial[i]);
                  quo_ff[i]  <= {quo_ff[i][QUO_W-2:0], 1'b0};
               end
               nlow_ff[i] <= nlow_ff[i] << 1;
            end
            step_ff <= step_ff - 5'd1;
         end
         BE_DONE: begin
            for (int i = 0; i < 3; i++) begin
               if (zero_ff) unit_ff[i] <= '0;
               else if (neg_ff[i]) unit_ff[i] <= -{1'b0, quo_ff[i]};
               else unit_ff[i] <= {1'b0, quo_ff[i]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == BE_DONE) begin
         rsp_zero_length <= zero_ff;
         rsp_last_out    <= last_ff;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_unit_x = unit_ff[0];
   assign rsp_unit_y = unit_ff[1];
   assign rsp_unit_z = unit_ff[2];
endmodule
`default_nettype wire

// ----- rtl/bond_unit_vector.sv -----
// Top level of the bond unit vector block: front end, queue and back end.
// Depends on buv_pkg, buv_front, buv_queue and buv_back.
//
// A write beat stores one atom in the coordinate table and gives no result. A
// compute beat holds busy after it is taken, through the fetch and push
// states, while the front end reads both atoms from the table and queues the
// difference vector; it can then take further beats while the back end works.
// The back end handles one bond at a time: it takes the bond, forms the
// squares and their sum, normalizes, runs a 31-bit bit-serial square root and
// three parallel bit-serial dividers with 17-bit quotients, and forms the
// signs; a zero-length bond goes from the sum straight to the signs. The
// result appears on rsp_* for one cycle with rsp_valid high; the receiver
// cannot stall it. Two bonds may wait in the queue; a further compute beat
// then keeps busy high until the back end takes one.
`default_nettype none
module bond_unit_vector #(
   parameter int ATOM_COUNT = 2048
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_func,
   input  wire logic [buv_pkg::IDX_W-1:0]           req_atom_first,
   input  wire logic [buv_pkg::IDX_W-1:0]           req_atom_second,
   input  wire logic signed [buv_pkg::COORD_W-1:0]  req_coord_x,
   input  wire logic signed [buv_pkg::COORD_W-1:0]  req_coord_y,
   input  wire logic signed [buv_pkg::COORD_W-1:0]  req_coord_z,
   input  wire logic                                req_last_in,
   output logic                                     rsp_valid,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_x,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_y,
   output logic signed [buv_pkg::UNIT_W-1:0]        rsp_unit_z,
   output logic                                     rsp_zero_length,
   output logic                                     rsp_last_out
);
   import buv_pkg::*;

   logic push_valid, push_ready, pop_valid, pop_ready;
   bond_type push_data, pop_data;

   buv_front #(.ATOM_COUNT(ATOM_COUNT)) u_front (
      .clock, .reset, .start, .busy,
      .req_func, .req_atom_first, .req_atom_second,
      .req_coord_x, .req_coord_y, .req_coord_z, .req_last_in,
      .push_valid, .push_data, .push_ready
   );

   buv_queue u_queue (
      .clock, .reset,
      .push_valid, .push_data, .push_ready,
      .pop_valid, .pop_data, .pop_ready
   );

   buv_back u_back (
      .clock, .reset,
      .pop_valid, .pop_data, .pop_ready,
      .rsp_valid, .rsp_unit_x, .rsp_unit_y, .rsp_unit_z,
      .rsp_zero_length, .rsp_last_out
   );
endmodule
`default_nettype wire

// ----- tb/sv/bond_unit_vector_tb.sv -----
// Self-checking testbench for bond_unit_vector: atom table writes and bond vector computes.
// Depends on buv_pkg and the bond_unit_vector RTL; the expected unit vectors come from an
// internal fixed-point predictor.
`default_nettype none
module bond_unit_vector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import buv_pkg::*;

   localparam int ATOMS = 2048;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef struct {
      logic signed [UNIT_W-1:0] ux;
      logic signed [UNIT_W-1:0] uy;
      logic signed [UNIT_W-1:0] uz;
      logic                     zero_len;
      logic                     last;
   } bond_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = FUNC_WRITE;
   logic [IDX_W-1:0] req_atom_first = '0;
   logic [IDX_W-1:0] req_atom_second = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic signed [UNIT_W-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic rsp_zero_length, rsp_last_out;

   logic [COORD_W-1:0] atom_x_tab [ATOMS];
   logic [COORD_W-1:0] atom_y_tab [ATOMS];
   logic [COORD_W-1:0] atom_z_tab [ATOMS];
   bit                 atom_written [ATOMS];
   int                 written_atoms [$];
   bond_result_type    pending_bonds [$];
   int                 failures = 0;
   bit                 idle_on = 1'b1;

   bond_unit_vector uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_atom_first(req_atom_first),
      .req_atom_second(req_atom_second), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_last_in(req_last_in), .rsp_valid(rsp_valid),
      .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y), .rsp_unit_z(rsp_unit_z),
      .rsp_zero_length(rsp_zero_length), .rsp_last_out(rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] t);
      logic [63:0] rem, root, bitv;
      rem = t;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > t) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [UNIT_W-1:0] scale_comp(input longint d, input int k,
                                                    input logic [63:0] mag);
      logic [127:0] num, quo;
      num = (d < 0) ? 128'(-d) : 128'(d);
      quo = (num << (16 + k)) / {64'd0, mag};
      if (d < 0) quo = -quo;
      return quo[UNIT_W-1:0];
   endfunction

   function automatic bond_result_type predict_bond(input int a1, input int a2,
                                                    input logic last);
      bond_result_type r;
      longint dx, dy, dz;
      logic [63:0] s, t;
      int k;
      dx = longint'($signed(atom_x_tab[a2])) - longint'($signed(atom_x_tab[a1]));
      dy = longint'($signed(atom_y_tab[a2])) - longint'($signed(atom_y_tab[a1]));
      dz = longint'($signed(atom_z_tab[a2])) - longint'($signed(atom_z_tab[a1]));
      s = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      r.last = last;
      if (s == 0) begin
         r.ux = '0;
         r.uy = '0;
         r.uz = '0;
         r.zero_len = 1'b1;
         return r;
      end
      t = s;
      k = 0;
      while (t < (64'd1 << 60)) begin
         t = t << 2;
         k++;
      end
      r.ux = scale_comp(dx, k, int_sqrt(t));
      r.uy = scale_comp(dy, k, int_sqrt(t));
      r.uz = scale_comp(dz, k, int_sqrt(t));
      r.zero_len = 1'b0;
      return r;
   endfunction

   task automatic send_beat(input logic func, input int a1, input int a2,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic last);
      @(negedge clock);
      start = 1'b1;
      req_func = func;
      req_atom_first = a1[IDX_W-1:0];
      req_atom_second = a2[IDX_W-1:0];
      req_coord_x = x;
      req_coord_y = y;
      req_coord_z = z;
      req_last_in = last;
      // busy only moves at the rising edge, so check it between edges
      while (busy) @(negedge clock);
      @(posedge clock);
      if (func == FUNC_WRITE) begin
         atom_x_tab[a1] = x;
         atom_y_tab[a1] = y;
         atom_z_tab[a1] = z;
         if (!atom_written[a1]) written_atoms.push_back(a1);
         atom_written[a1] = 1'b1;
      end else begin
         pending_bonds.push_back(predict_bond(a1, a2, last));
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   task automatic write_atom(input int a, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      send_beat(FUNC_WRITE, a, $urandom_range(0, ATOMS - 1), x, y, z, 1'($urandom));
   endtask

   task automatic compute_bond(input int a1, input int a2, input logic last);
      send_beat(FUNC_COMPUTE, a1, a2, 24'($urandom), 24'($urandom), 24'($urandom), last);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 24'($signed(11'($urandom)));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic int pick_atom();
      return written_atoms[$urandom_range(0, written_atoms.size() - 1)];
   endfunction

   // extremes of the table and the coordinate range
   task automatic test_extremes();
      write_atom(0, COORD_MAX, COORD_MAX, COORD_MAX);
      write_atom(ATOMS - 1, COORD_MIN, COORD_MIN, COORD_MIN);
      compute_bond(0, ATOMS - 1, 1'b0);
      compute_bond(ATOMS - 1, 0, 1'b1);
      write_atom(1, COORD_MAX, COORD_MIN, 24'd0);
      compute_bond(1, 0, 1'b0);
      compute_bond(ATOMS - 1, 1, 1'b1);
   endtask

   // coincident atoms, one-LSB bonds, axis bonds and a write that overwrites
   task automatic test_special_cases();
      write_atom(5, 24'd0, 24'd0, 24'd0);
      write_atom(6, 24'd1, 24'd0, 24'd0);
      write_atom(7, 24'd0, 24'd0, -24'sd1);
      write_atom(8, 24'd1, 24'd1, 24'd1);
      compute_bond(5, 5, 1'b1);
      compute_bond(5, 6, 1'b0);
      compute_bond(5, 7, 1'b1);
      compute_bond(6, 8, 1'b0);
      compute_bond(8, 5, 1'b1);
      write_atom(9, 24'd1, 24'd1, 24'd1);
      compute_bond(8, 9, 1'b0);
      write_atom(9, 24'h123456, -24'sh0ABCDE, 24'h000777);
      compute_bond(8, 9, 1'b1);
   endtask

   task automatic test_random(input int count);
      int a;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(0, ATOMS - 1);
               write_atom(a, rand_coord(), rand_coord(), rand_coord());
            end
            4: begin
               a = pick_atom();
               compute_bond(a, a, 1'($urandom));
            end
            default: compute_bond(pick_atom(), pick_atom(), 1'($urandom));
         endcase
      end
   endtask

   // back-to-back beats so the queue fills and busy holds the sender
   task automatic test_streaming(input int count);
      idle_on = 1'b0;
      test_random(count);
      @(negedge clock);
      start = 1'b0;
   endtask

   always @(posedge clock) begin
      bond_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_bonds.size() == 0) begin
            $error("result with nothing expected");
            failures++;
         end else begin
            e = pending_bonds.pop_front();
            if (rsp_unit_x !== e.ux) begin
               $error("unit_x expected %0d actual %0d", e.ux, rsp_unit_x);
               failures++;
            end
            if (rsp_unit_y !== e.uy) begin
               $error("unit_y expected %0d actual %0d", e.uy, rsp_unit_y);
               failures++;
            end
            if (rsp_unit_z !== e.uz) begin
               $error("unit_z expected %0d actual %0d", e.uz, rsp_unit_z);
               failures++;
            end
            if (rsp_zero_length !== e.zero_len) begin
               $error("zero_length expected %0d actual %0d", e.zero_len, rsp_zero_length);
               failures++;
            end
            if (rsp_last_out !== e.last) begin
               $error("last_out expected %0d actual %0d", e.last, rsp_last_out);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_special_cases();
      test_random(400);
      test_streaming(100);
      while (pending_bonds.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (pending_bonds.size() != 0) begin
         $error("expected results left over");
         failures++;
      end
      if (failures == 0) begin
         $display("bond_unit_vector regression: pass");
      end else begin
         $display("bond_unit_vector regression: fail");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("bond_unit_vector regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
